// File: rtl/ppwmf_pkg.sv
`timescale 1ns / 1ps

package ppwmf_pkg;

   // Default capacities of the history store.
   localparam int unsigned DEF_MAX_WORD_LEN = 16;
   localparam int unsigned DEF_MAX_WINDOW   = 16;

   // Fixed field widths of the channels and the register port.
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned POSITION_W = 4;
   localparam int unsigned CSR_DATA_W = 5;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned RSP_DATA_W = 16;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_WORD_LEN   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LEN = 1'b1;

   // Register reset values.
   localparam logic [CSR_DATA_W-1:0] RST_WORD_LEN   = 5'd8;
   localparam logic [CSR_DATA_W-1:0] RST_WINDOW_LEN = 5'd5;

   // Byte used to fill positions of a word that ends short.
   localparam logic [CHAR_W-1:0] PAD_BYTE = 8'h20;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_LOAD,
      ST_COUNT,
      ST_DRAIN,
      ST_EMIT,
      ST_END
   } seq_state_type;

   // Strobes from the sequencer to the mode unit.
   typedef struct packed {
      logic clear;
      logic load;
      logic count;
   } mode_ctl_type;

   // Clamp a length register into the range 1 .. maxv.
   function automatic int unsigned clamp_len(logic [CSR_DATA_W-1:0] v, int unsigned maxv);
      int unsigned r;
      r = int'(v);
      if (r < 1) begin
         r = 1;
      end else if (r > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

// File: rtl/ppwmf_hist_mem.sv
`timescale 1ns / 1ps

module ppwmf_hist_mem import ppwmf_pkg::*; #(
   parameter int unsigned DEPTH  = DEF_MAX_WORD_LEN * DEF_MAX_WINDOW,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wen,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [CHAR_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [CHAR_W-1:0] rdata
);

   logic [CHAR_W-1:0] mem [DEPTH];
   logic [CHAR_W-1:0] rdata_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ppwmf_mode_unit.sv
`timescale 1ns / 1ps

module ppwmf_mode_unit import ppwmf_pkg::*; #(
   parameter int unsigned MAX_WINDOW = DEF_MAX_WINDOW,
   parameter int unsigned WIN_IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   parameter int unsigned WIN_CNT_W  = $clog2(MAX_WINDOW + 1)
) (
   input  logic                 clock,
   input  mode_ctl_type         ctl,
   input  logic [WIN_CNT_W-1:0] wn,
   input  logic [WIN_IDX_W-1:0] load_idx,
   input  logic [CHAR_W-1:0]    data,
   output logic [CHAR_W-1:0]    best
);

   logic [CHAR_W-1:0]    win_ff [MAX_WINDOW];
   logic [CHAR_W-1:0]    best_ff;
   logic [WIN_CNT_W-1:0] best_cnt_ff;
   logic [WIN_CNT_W-1:0] cnt;

   // Shared counting unit: occurrences of the candidate among the active entries.
   always_comb begin
      cnt = '0;
      for (int k = 0; k < MAX_WINDOW; k++) begin
         if ((WIN_CNT_W'(k) < wn) && (win_ff[k] == data)) begin
            cnt = cnt + WIN_CNT_W'(1);
         end
      end
   end

   // Window copy, filled one entry per transfer from the history store.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         win_ff[load_idx] <= data;
      end
   end

   // Running best; candidates arrive oldest first, so only a strictly larger
   // count replaces the held value.
   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end else if (ctl.count && (cnt > best_cnt_ff)) begin
         best_ff     <= data;
         best_cnt_ff <= cnt;
      end
   end

   assign best = best_ff;

endmodule

// File: rtl/per_position_window_mode_filter_core.sv
`timescale 1ns / 1ps

// Per-position sliding-window mode filter.
// Input channel (req_): one character per transfer; tlast marks the end of a
// word, tuser marks a transfer without a character (an empty word carries
// tuser and tlast together). Result channel (rsp_): one transfer per
// character position, carrying the most frequent byte of that position's
// window, the position, and tlast on position word_len - 1.
// Configuration (csr_): index 0 is word_len, index 1 is window_len; a write
// to either clears all windows, the slot pointer and the word position.
// Each result first copies the W entries of its window out of the history
// store, W being window_len clamped to 1 .. MAX_WINDOW, one history read per
// cycle, then passes one candidate per cycle through the shared counting
// unit. An item is accepted, then each result it causes (up to word_len
// results with padding) is worked out in turn; a word's end adds an end step.
// Reset restores word_len 8 and window_len 5 and all windows to zero bytes;
// the windows need no clearing pass. The block accepts nothing while an item
// is in work. A result is held in an output register; when the receiver
// stalls, work on the next position runs on and then waits for that register.

module per_position_window_mode_filter_core import ppwmf_pkg::*; #(
   parameter int unsigned MAX_WORD_LEN = DEF_MAX_WORD_LEN,
   parameter int unsigned MAX_WINDOW   = DEF_MAX_WINDOW
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_in
   input  logic                  req_tlast,   // end_of_word
   input  logic                  req_tuser,   // [0] no_char
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [7:0] char_out, [11:8] position, rest zero
   output logic                  rsp_tlast,   // last
   // Configuration port
   input  logic                  csr_wen,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned DEPTH     = MAX_WORD_LEN * MAX_WINDOW;
   localparam int unsigned ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned POS_W     = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
   localparam int unsigned POS_CNT_W = $clog2(MAX_WORD_LEN + 1);
   localparam int unsigned WIN_IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int unsigned WIN_CNT_W = $clog2(MAX_WINDOW + 1);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WINDOW);

   seq_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] word_len_ff;
   logic [CSR_DATA_W-1:0] window_len_ff;
   logic [WIN_IDX_W-1:0]  ring_ptr_ff;
   logic                  wrapped_ff;
   logic [POS_CNT_W-1:0]  char_pos_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [CHAR_W-1:0]     byte_ff;
   logic                  eow_ff;
   logic [WIN_IDX_W-1:0]  rd_slot_ff;
   logic [WIN_IDX_W-1:0]  rd_cnt_ff;
   logic                  rd_load_ff;
   logic                  rd_count_ff;
   logic [WIN_IDX_W-1:0]  rd_idx_ff;
   logic                  rd_ok_ff;
   logic                  rsp_tvalid_ff;
   logic [CHAR_W-1:0]     char_out_ff;
   logic [POS_W-1:0]      position_ff;
   logic                  last_ff;

   logic [POS_CNT_W-1:0]  wl;
   logic [WIN_CNT_W-1:0]  wn;
   logic                  req_fire;
   logic                  has_char;
   logic                  emit_fire;
   logic [POS_CNT_W-1:0]  next_pos;
   logic                  slot_last;
   logic [WIN_IDX_W-1:0]  slot_next;
   logic                  ring_last;
   logic [WIN_IDX_W-1:0]  oldest;
   logic                  cnt_last;
   logic                  mem_wen;
   logic [ADDR_W-1:0]     row_base;
   logic [ADDR_W-1:0]     waddr;
   logic [ADDR_W-1:0]     raddr;
   logic [CHAR_W-1:0]     rdata;
   logic [CHAR_W-1:0]     rd_byte;
   logic [CHAR_W-1:0]     best;
   logic                  csr_clear;
   mode_ctl_type          mode_ctl;

   // Effective lengths after clamping.
   assign wl = POS_CNT_W'(clamp_len(word_len_ff, MAX_WORD_LEN));
   assign wn = WIN_CNT_W'(clamp_len(window_len_ff, MAX_WINDOW));

   assign req_fire  = req_tvalid && req_tready;
   assign has_char  = !req_tuser && (char_pos_ff < wl);
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);
   assign next_pos  = POS_CNT_W'(pos_ff) + POS_CNT_W'(1);

   // Modular stepping of slot indexes within the active window.
   assign slot_last = (WIN_CNT_W'(rd_slot_ff) + WIN_CNT_W'(1)) == wn;
   assign slot_next = slot_last ? '0 : rd_slot_ff + WIN_IDX_W'(1);
   assign ring_last = (WIN_CNT_W'(ring_ptr_ff) + WIN_CNT_W'(1)) == wn;
   assign oldest    = ring_last ? '0 : ring_ptr_ff + WIN_IDX_W'(1);
   assign cnt_last  = (WIN_CNT_W'(rd_cnt_ff) + WIN_CNT_W'(1)) == wn;

   // History addressing: one row per position.
   assign row_base = ADDR_W'(pos_ff) * ROW_STRIDE;
   assign waddr    = row_base + ADDR_W'(ring_ptr_ff);
   assign raddr    = row_base + ADDR_W'(rd_slot_ff);

   // Slots not yet written since the last clear read as zero bytes.
   assign rd_byte = rd_ok_ff ? rdata : '0;

   assign csr_clear = csr_wen &&
                      ((csr_index == CSR_WORD_LEN) || (csr_index == CSR_WINDOW_LEN));

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and control strobes.
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      mem_wen        = 1'b0;
      mode_ctl.clear = 1'b0;
      mode_ctl.load  = rd_load_ff;
      mode_ctl.count = rd_count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (has_char) begin
                  state_in = ST_WRITE;
               end else if (req_tlast) begin
                  state_in = (char_pos_ff < wl) ? ST_WRITE : ST_END;
               end
            end
         end
         ST_WRITE: begin
            mem_wen        = 1'b1;
            mode_ctl.clear = 1'b1;
            state_in       = ST_LOAD;
         end
         ST_LOAD: begin
            if (cnt_last) begin
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) begin
               if (eow_ff && (next_pos < wl)) begin
                  state_in = ST_WRITE;
               end else if (eow_ff) begin
                  state_in = ST_END;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_END: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Word position, slot pointer, registers and read pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_len_ff   <= RST_WORD_LEN;
         window_len_ff <= RST_WINDOW_LEN;
         ring_ptr_ff   <= '0;
         wrapped_ff    <= 1'b0;
         char_pos_ff   <= '0;
         rd_load_ff    <= 1'b0;
         rd_count_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rd_load_ff  <= (state_ff == ST_LOAD);
         rd_count_ff <= (state_ff == ST_COUNT);

         // Output register: cleared on a transfer, loaded on a new result.
         if (emit_fire) begin
            rsp_tvalid_ff <= 1'b1;
            char_pos_ff   <= next_pos;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end

         if (state_ff == ST_END) begin
            ring_ptr_ff <= oldest;
            char_pos_ff <= '0;
            if (ring_last) begin
               wrapped_ff <= 1'b1;
            end
         end

         // A write to either register restarts every window.
         if (csr_wen && (csr_index == CSR_WORD_LEN)) begin
            word_len_ff <= csr_wdata;
         end
         if (csr_wen && (csr_index == CSR_WINDOW_LEN)) begin
            window_len_ff <= csr_wdata;
         end
         if (csr_clear) begin
            ring_ptr_ff <= '0;
            wrapped_ff  <= 1'b0;
            char_pos_ff <= '0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= has_char ? req_tdata : PAD_BYTE;
         eow_ff  <= req_tlast;
         pos_ff  <= POS_W'(char_pos_ff);
      end

      if (state_ff == ST_WRITE) begin
         rd_slot_ff <= oldest;
         rd_cnt_ff  <= '0;
      end else if ((state_ff == ST_LOAD) || (state_ff == ST_COUNT)) begin
         rd_slot_ff <= slot_next;
         rd_cnt_ff  <= cnt_last ? '0 : rd_cnt_ff + WIN_IDX_W'(1);
      end

      rd_idx_ff <= rd_cnt_ff;
      rd_ok_ff  <= wrapped_ff || (rd_slot_ff <= ring_ptr_ff);

      if (emit_fire) begin
         char_out_ff <= best;
         position_ff <= pos_ff;
         last_ff     <= (next_pos == wl);
         if (eow_ff && (next_pos < wl)) begin
            pos_ff  <= POS_W'(next_pos);
            byte_ff <= PAD_BYTE;
         end
      end
   end

   ppwmf_hist_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_hist_mem (
      .clock (clock),
      .wen   (mem_wen),
      .waddr (waddr),
      .wdata (byte_ff),
      .raddr (raddr),
      .rdata (rdata)
   );

   ppwmf_mode_unit #(
      .MAX_WINDOW (MAX_WINDOW),
      .WIN_IDX_W  (WIN_IDX_W),
      .WIN_CNT_W  (WIN_CNT_W)
   ) u_mode_unit (
      .clock    (clock),
      .ctl      (mode_ctl),
      .wn       (wn),
      .load_idx (rd_idx_ff),
      .data     (rd_byte),
      .best     (best)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - CHAR_W - POSITION_W)'(0),
                        POSITION_W'(position_ff), char_out_ff};
   assign rsp_tlast  = last_ff;

endmodule

// File: test/per_position_window_mode_filter_core_test.sv
`timescale 1ns / 1ps

module per_position_window_mode_filter_core_test;
   import ppwmf_pkg::*;

   localparam int MAX_POS        = 16;
   localparam int MAX_DEPTH      = 16;
   localparam int SETTLE_CYCLES  = 60;
   localparam int QUIET_LIMIT    = 3000;
   localparam int PHASE_ITEMS    = 68;
   localparam int RANDOM_PHASES  = 6;
   localparam int TAIL_ITEMS     = 30;

   // One smoothed character as it should appear on the result channel.
   typedef struct packed {
      logic [CHAR_W-1:0]     ch;
      logic [POSITION_W-1:0] pos;
      logic                  last;
   } mode_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [CHAR_W-1:0]     req_tdata  = '0;   // [7:0] char_in
   logic                  req_tlast  = 1'b0; // end_of_word
   logic                  req_tuser  = 1'b0; // [0] no_char
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [7:0] char_out, [11:8] position, rest zero
   logic                  rsp_tlast;         // last
   logic                  csr_wen    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_WORD_LEN;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Shadow of the filter state.
   logic [CHAR_W-1:0]     win_hist [MAX_POS][MAX_DEPTH];
   int                    slot_ptr;
   int                    fill_pos;
   logic [CSR_DATA_W-1:0] cfg_word_len;
   logic [CSR_DATA_W-1:0] cfg_window_len;

   mode_result_type pending_modes [$];
   int              errors;
   int              items_sent;
   int              quiet_cycles;
   logic            req_idle_on;
   logic            rsp_idle_on;

   // The word currently being "read", before recognition noise.
   logic [CHAR_W-1:0] clean_word [20];
   int                clean_len;

   per_position_window_mode_filter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A length register of zero acts as one; anything above the capacity acts as the capacity.
   function automatic int bound_len(input logic [CSR_DATA_W-1:0] v, input int maxv);
      if (v == 0) begin
         return 1;
      end
      if (int'(v) > maxv) begin
         return maxv;
      end
      return int'(v);
   endfunction

   function automatic void clear_windows();
      foreach (win_hist[p, s]) begin
         win_hist[p][s] = '0;
      end
      slot_ptr = 0;
      fill_pos = 0;
   endfunction

   // Store one byte in a position's window and queue the window's most frequent byte.
   // Ties go to the byte that appears first when the window is read oldest first.
   function automatic void push_position(input int pos, input int wl, input int wn,
                                         input logic [CHAR_W-1:0] c);
      int                slot;
      int                oldest;
      int                best_cnt;
      int                cnt;
      logic [CHAR_W-1:0] best;
      logic [CHAR_W-1:0] v;
      mode_result_type   r;
      slot     = slot_ptr % wn;
      oldest   = (slot + 1) % wn;
      best_cnt = 0;
      best     = '0;
      win_hist[pos][slot] = c;
      for (int i = 0; i < wn; i++) begin
         v   = win_hist[pos][(oldest + i) % wn];
         cnt = 0;
         for (int j = 0; j < wn; j++) begin
            if (win_hist[pos][j] == v) begin
               cnt++;
            end
         end
         if (cnt > best_cnt) begin
            best_cnt = cnt;
            best     = v;
         end
      end
      r.ch   = best;
      r.pos  = pos[POSITION_W-1:0];
      r.last = (pos + 1 == wl);
      pending_modes.insert(pending_modes.size(), r);
   endfunction

   // Work out the results caused by one accepted input transfer.
   function automatic void predict_mode_results(input logic [CHAR_W-1:0] c, input logic eow,
                                                input logic none);
      int wl;
      int wn;
      wl = bound_len(cfg_word_len, MAX_POS);
      wn = bound_len(cfg_window_len, MAX_DEPTH);
      if (!none && fill_pos < wl) begin
         push_position(fill_pos, wl, wn, c);
         fill_pos++;
      end
      if (eow) begin
         while (fill_pos < wl) begin
            push_position(fill_pos, wl, wn, PAD_BYTE);
            fill_pos++;
         end
         slot_ptr = (slot_ptr + 1) % wn;
         fill_pos = 0;
      end
   endfunction

   // Result checker: every result transfer is matched against the oldest prediction.
   always @(posedge clock) begin : check_results
      mode_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_modes.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_modes[0];
            pending_modes.delete(0);
            if (rsp_tdata[7:0] !== want.ch) begin
               errors++;
               $display("%0t: char_out mismatch, expected %h, actual %h",
                        $time, want.ch, rsp_tdata[7:0]);
            end
            if (rsp_tdata[11:8] !== want.pos) begin
               errors++;
               $display("%0t: position mismatch, expected %0d, actual %0d",
                        $time, want.pos, rsp_tdata[11:8]);
            end
            if (rsp_tdata[RSP_DATA_W-1:12] !== '0) begin
               errors++;
               $display("%0t: padding bits mismatch, expected 0, actual %h",
                        $time, rsp_tdata[RSP_DATA_W-1:12]);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last mismatch, expected %b, actual %b",
                        $time, want.last, rsp_tlast);
            end
         end
      end
   end

   // Receiver: ready drops in random bursts while stalling is enabled.
   always begin
      @(posedge clock);
      if (rsp_idle_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      rsp_tready <= 1'b1;
   end

   // Watchdog: the run is abandoned after too long without any transfer.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one item and hold it until the block takes it; may leave a gap afterwards.
   task automatic send_item(input logic [CHAR_W-1:0] ch, input logic eow, input logic none);
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tlast  <= eow;
      req_tuser  <= none;
      do @(posedge clock); while (!req_tready);
      predict_mode_results(ch, eow, none);
      if (!(none && !eow)) begin
         items_sent++;
      end
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Stop sending and wait for every predicted result, then let the block settle.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_modes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_WORD_LEN) begin
         cfg_word_len = val;
      end else begin
         cfg_window_len = val;
      end
      clear_windows();
      csr_wen <= 1'b0;
      @(posedge clock);
   endtask

   // Send one reading of the current word with occasional recognition errors,
   // dropped characters and stray empty transfers.
   task automatic send_noisy_word();
      int                len;
      logic [CHAR_W-1:0] c;
      logic              split_end;
      if ($urandom_range(0, 3) == 0 || clean_len == 0) begin
         clean_len = $urandom_range(1, bound_len(cfg_word_len, MAX_POS) + 2);
         for (int k = 0; k < clean_len; k++) begin
            clean_word[k] = 8'h61 + CHAR_W'($urandom_range(0, 25));
         end
      end
      len = clean_len;
      if (len > 1 && $urandom_range(0, 5) == 0) begin
         len--;
      end
      split_end = ($urandom_range(0, 6) == 0);
      for (int k = 0; k < len; k++) begin
         c = clean_word[k];
         if ($urandom_range(0, 5) == 0) begin
            c = CHAR_W'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 15) == 0) begin
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1);
         end
         send_item(c, (k == len - 1) && !split_end, 1'b0);
      end
      if (split_end) begin
         send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
   endtask

   // Reset values; windows start as zero bytes, so zeros win early on.
   // Also covers empty words, ignored transfers and overlong words.
   task automatic test_reset_defaults();
      send_item(8'h41, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h5A, 1'b0, 1'b1);
      send_item(8'hA5, 1'b1, 1'b1);
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h55, 1'b0, 1'b0);
      send_item(8'hAA, 1'b0, 1'b0);
      send_item(8'h01, 1'b0, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h0F, 1'b0, 1'b0);
      send_item(8'hF0, 1'b0, 1'b0);
      send_item(8'h33, 1'b0, 1'b0);
      send_item(8'hCC, 1'b0, 1'b0);
      send_item(8'h7E, 1'b0, 1'b0);
      send_item(8'h81, 1'b1, 1'b0);
      wait_for_drain();
   endtask

   // Register values at and beyond both ends of their ranges.
   task automatic test_length_extremes();
      write_csr(CSR_WORD_LEN, 5'd0);
      write_csr(CSR_WINDOW_LEN, 5'd31);
      send_item(8'h78, 1'b0, 1'b0);
      send_item(8'h79, 1'b1, 1'b0);
      wait_for_drain();
      write_csr(CSR_WORD_LEN, 5'd31);
      write_csr(CSR_WINDOW_LEN, 5'd0);
      send_item(8'h7A, 1'b1, 1'b0);
      wait_for_drain();
      write_csr(CSR_WINDOW_LEN, 5'd16);
      write_csr(CSR_WORD_LEN, 5'd16);
      send_item(8'h61, 1'b1, 1'b0);
      wait_for_drain();
      write_csr(CSR_WORD_LEN, 5'd1);
      write_csr(CSR_WINDOW_LEN, 5'd1);
      send_item(8'h62, 1'b1, 1'b0);
      send_item(8'h63, 1'b1, 1'b0);
      wait_for_drain();
   endtask

   // Phases of repeated noisy words under random lengths, with stray transfers mixed in.
   task automatic test_random_traffic();
      int goal;
      int pick;
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         pick = $urandom_range(0, 3);
         if (pick != 1) begin
            write_csr(CSR_WORD_LEN,
                      CSR_DATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                             : $urandom_range(0, 31)));
         end
         if (pick != 2) begin
            write_csr(CSR_WINDOW_LEN,
                      CSR_DATA_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                             : $urandom_range(0, 31)));
         end
         req_idle_on = ($urandom_range(0, 3) != 0);
         rsp_idle_on = ($urandom_range(0, 3) != 0);
         clean_len   = 0;
         goal        = items_sent + PHASE_ITEMS;
         while (items_sent < goal) begin
            pick = $urandom_range(0, 19);
            if (pick < 15) begin
               send_noisy_word();
            end else if (pick < 18) begin
               send_item(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
            end else if (pick < 19) begin
               send_item(CHAR_W'($urandom_range(0, 255)), 1'b1, 1'b1);
            end else begin
               wait_for_drain();
            end
         end
         wait_for_drain();
      end
   endtask

   // Closing stretch with both sides running flat out.
   task automatic test_quiet_tail();
      int goal;
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      goal        = items_sent + TAIL_ITEMS;
      while (items_sent < goal) begin
         send_noisy_word();
      end
      wait_for_drain();
   endtask

   initial begin
      errors         = 0;
      items_sent     = 0;
      quiet_cycles   = 0;
      clean_len      = 0;
      req_idle_on    = 1'b1;
      rsp_idle_on    = 1'b1;
      cfg_word_len   = RST_WORD_LEN;
      cfg_window_len = RST_WINDOW_LEN;
      clear_windows();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_length_extremes();
      test_random_traffic();
      test_quiet_tail();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
